// ----- rtl/core/tfn_pkg.sv -----
// tfn_pkg: widths, controller states, datapath op codes and the
// command/status structs shared by the triangle face normal block.
// No dependencies.
`timescale 1ns / 1ps
package tfn_pkg;

   localparam int IDX_W      = 12;
   localparam int POS_W      = 24;
   localparam int EDGE_W     = 25;
   localparam int PROD_W     = 50;
   localparam int CROSS_W    = 51;
   localparam int MAG_W      = 50;
   localparam int U_W        = 18;
   localparam int SQ_W       = 36;
   localparam int SUM_W      = 38;
   localparam int QUO_W      = 29;
   localparam int ROOT_W     = 30;
   localparam int NRM_W      = 16;
   localparam int STEP_W     = 5;
   localparam int COMP_W     = 2;
   localparam int MUL_LAST   = 6;
   localparam int SQ_LAST    = 2;
   localparam int DIV_LAST   = QUO_W - 1;
   localparam int SQRT_LAST  = 14;
   localparam int COMP_LAST  = 2;
   localparam int NORM_LO_EXP = 17;
   localparam int NORM_HI_EXP = 18;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_C, ST_CAP_C, ST_EDGE, ST_MUL, ST_ABS,
      ST_MAX, ST_NORM, ST_SQ, ST_SUM, ST_DIV_INIT, ST_DIV, ST_SQRT_INIT,
      ST_SQRT, ST_STORE, ST_DONE
   } tfn_state_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_ACCEPT, OP_RD_A, OP_RD_B, OP_RD_C, OP_CAP_C, OP_EDGE,
      OP_MUL, OP_ABS, OP_MAX, OP_NORM, OP_SQ, OP_SUM, OP_DIV_INIT, OP_DIV_STEP,
      OP_SQRT_INIT, OP_SQRT_STEP, OP_STORE, OP_RSP
   } tfn_op_type;

   typedef struct packed {
      tfn_op_type          op;
      logic [STEP_W-1:0]   step;
      logic [COMP_W-1:0]   comp;
   } tfn_cmd_type;

   typedef struct packed {
      logic zero;      // cross product is all zero
      logic norm_ok;   // largest magnitude sits in [2^17, 2^18)
   } tfn_status_type;

endpackage

// ----- rtl/core/triangle_face_normal.sv -----
// triangle_face_normal: top level, controller plus datapath.
// Depends on tfn_pkg, tfn_ctrl, tfn_datapath (which holds tfn_ram).
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    req_type, vertex_index, pos_xyz, corner_abc
//   rsp      out  rsp_valid/stall    normal_xyz (Q1.14), zero_area
//
// A load item is written to the vertex store as it is accepted.
// A triangle item takes 3 store reads, an edge step and the multiply/accumulate
// steps of the cross product, then one-bit normalize shifts until the largest
// magnitude sits in [2^17, 2^18), and per component a 29-step divider plus a
// 15-step square root. A degenerate triangle skips normalize, divide and root.
// Reset clears only control; the vertex store holds garbage until written.
// req_stall is high while a triangle is in flight; a finished result waits in the
// output register under rsp_stall while the next item may already be accepted.
`timescale 1ns / 1ps
module triangle_face_normal #(
   parameter int MAX_VERTICES = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [tfn_pkg::IDX_W-1:0]          req_vertex_index,
   input  logic signed [tfn_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [tfn_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [tfn_pkg::POS_W-1:0]   req_pos_z,
   input  logic [tfn_pkg::IDX_W-1:0]          req_corner_a,
   input  logic [tfn_pkg::IDX_W-1:0]          req_corner_b,
   input  logic [tfn_pkg::IDX_W-1:0]          req_corner_c,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tfn_pkg::NRM_W-1:0]   rsp_normal_x,
   output logic signed [tfn_pkg::NRM_W-1:0]   rsp_normal_y,
   output logic signed [tfn_pkg::NRM_W-1:0]   rsp_normal_z,
   output logic                               rsp_zero_area
);
   tfn_pkg::tfn_cmd_type    cmd;
   tfn_pkg::tfn_status_type status;

   tfn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tfn_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_vertex_index (req_vertex_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_zero_area    (rsp_zero_area)
   );
endmodule

// ----- rtl/core/tfn_ram.sv -----
// tfn_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module tfn_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/tfn_ctrl.sv -----
// tfn_ctrl: sequencer for load and triangle items; issues datapath commands.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
module tfn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_type,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  tfn_pkg::tfn_status_type status,
   output tfn_pkg::tfn_cmd_type    cmd
);
   tfn_pkg::tfn_state_type          state_ff, state_in;
   logic [tfn_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [tfn_pkg::COMP_W-1:0]      comp_ff, comp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfn_pkg::ST_IDLE;
         step_ff      <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      comp_in      = comp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      req_stall    = 1'b1;
      cmd.op       = tfn_pkg::OP_NOP;
      cmd.step     = step_ff;
      cmd.comp     = comp_ff;
      case (state_ff)
         tfn_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_type) begin
                  cmd.op   = tfn_pkg::OP_ACCEPT;
                  state_in = tfn_pkg::ST_RD_A;
               end else begin
                  cmd.op = tfn_pkg::OP_LOAD;
               end
            end
         end
         tfn_pkg::ST_RD_A: begin
            cmd.op   = tfn_pkg::OP_RD_A;
            state_in = tfn_pkg::ST_RD_B;
         end
         tfn_pkg::ST_RD_B: begin
            cmd.op   = tfn_pkg::OP_RD_B;
            state_in = tfn_pkg::ST_RD_C;
         end
         tfn_pkg::ST_RD_C: begin
            cmd.op   = tfn_pkg::OP_RD_C;
            state_in = tfn_pkg::ST_CAP_C;
         end
         tfn_pkg::ST_CAP_C: begin
            cmd.op   = tfn_pkg::OP_CAP_C;
            state_in = tfn_pkg::ST_EDGE;
         end
         tfn_pkg::ST_EDGE: begin
            cmd.op   = tfn_pkg::OP_EDGE;
            step_in  = '0;
            state_in = tfn_pkg::ST_MUL;
         end
         tfn_pkg::ST_MUL: begin
            cmd.op = tfn_pkg::OP_MUL;
            if (step_ff == tfn_pkg::STEP_W'(tfn_pkg::MUL_LAST)) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_ABS;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tfn_pkg::ST_ABS: begin
            cmd.op   = tfn_pkg::OP_ABS;
            state_in = tfn_pkg::ST_MAX;
         end
         tfn_pkg::ST_MAX: begin
            cmd.op   = tfn_pkg::OP_MAX;
            state_in = tfn_pkg::ST_NORM;
         end
         tfn_pkg::ST_NORM: begin
            if (status.zero) begin
               state_in = tfn_pkg::ST_DONE;
            end else if (status.norm_ok) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_SQ;
            end else begin
               cmd.op = tfn_pkg::OP_NORM;
            end
         end
         tfn_pkg::ST_SQ: begin
            cmd.op = tfn_pkg::OP_SQ;
            if (step_ff == tfn_pkg::STEP_W'(tfn_pkg::SQ_LAST)) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_SUM;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tfn_pkg::ST_SUM: begin
            cmd.op   = tfn_pkg::OP_SUM;
            comp_in  = '0;
            state_in = tfn_pkg::ST_DIV_INIT;
         end
         tfn_pkg::ST_DIV_INIT: begin
            cmd.op   = tfn_pkg::OP_DIV_INIT;
            step_in  = '0;
            state_in = tfn_pkg::ST_DIV;
         end
         tfn_pkg::ST_DIV: begin
            cmd.op = tfn_pkg::OP_DIV_STEP;
            if (step_ff == tfn_pkg::STEP_W'(tfn_pkg::DIV_LAST)) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_SQRT_INIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tfn_pkg::ST_SQRT_INIT: begin
            cmd.op   = tfn_pkg::OP_SQRT_INIT;
            step_in  = '0;
            state_in = tfn_pkg::ST_SQRT;
         end
         tfn_pkg::ST_SQRT: begin
            cmd.op = tfn_pkg::OP_SQRT_STEP;
            if (step_ff == tfn_pkg::STEP_W'(tfn_pkg::SQRT_LAST)) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_STORE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tfn_pkg::ST_STORE: begin
            cmd.op = tfn_pkg::OP_STORE;
            if (comp_ff == tfn_pkg::COMP_W'(tfn_pkg::COMP_LAST)) begin
               comp_in  = '0;
               state_in = tfn_pkg::ST_DONE;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = tfn_pkg::ST_DIV_INIT;
            end
         end
         tfn_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = tfn_pkg::OP_RSP;
               rsp_valid_in = 1'b1;
               state_in     = tfn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tfn_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- rtl/core/tfn_datapath.sv -----
// tfn_datapath: vertex store, edges, cross product, normalize shift,
// restoring divider, digit square root and result register.
// Depends on tfn_pkg and tfn_ram.
`timescale 1ns / 1ps
module tfn_datapath #(
   parameter int MAX_VERTICES = 4096
) (
   input  logic                              clock,
   input  tfn_pkg::tfn_cmd_type              cmd,
   output tfn_pkg::tfn_status_type           status,
   input  logic [tfn_pkg::IDX_W-1:0]         req_vertex_index,
   input  logic signed [tfn_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [tfn_pkg::POS_W-1:0]  req_pos_y,
   input  logic signed [tfn_pkg::POS_W-1:0]  req_pos_z,
   input  logic [tfn_pkg::IDX_W-1:0]         req_corner_a,
   input  logic [tfn_pkg::IDX_W-1:0]         req_corner_b,
   input  logic [tfn_pkg::IDX_W-1:0]         req_corner_c,
   output logic signed [tfn_pkg::NRM_W-1:0]  rsp_normal_x,
   output logic signed [tfn_pkg::NRM_W-1:0]  rsp_normal_y,
   output logic signed [tfn_pkg::NRM_W-1:0]  rsp_normal_z,
   output logic                              rsp_zero_area
);
   localparam int AW    = $clog2(MAX_VERTICES);
   // one bit above both index widths so MAX_VERTICES itself fits in compares
   localparam int EW    = ((AW > tfn_pkg::IDX_W) ? AW : tfn_pkg::IDX_W) + 1;
   localparam int VEC_W = 3 * tfn_pkg::POS_W;

   typedef logic signed [tfn_pkg::POS_W-1:0]   pos_type;
   typedef logic signed [tfn_pkg::EDGE_W-1:0]  edge_type;
   typedef logic signed [tfn_pkg::CROSS_W-1:0] cross_type;

   // store access
   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [VEC_W-1:0]  rd_data;
   logic [EW-1:0]     ext_v, ext_a, ext_b, ext_c;

   logic [AW-1:0]     addr_ff [3];
   logic              inr_ff [3];
   pos_type           vtx_ff [3][3];   // [corner][axis]
   edge_type          e0_ff [3], e1_ff [3];
   logic signed [tfn_pkg::PROD_W-1:0] prod_ff;
   cross_type         cr_ff [3];
   logic              neg_ff [3];
   logic [tfn_pkg::MAG_W-1:0] mag_ff [3];
   logic [tfn_pkg::MAG_W-1:0] max_ff;
   logic              zero_ff;
   logic [tfn_pkg::SQ_W-1:0]  sq_ff [3];
   logic [tfn_pkg::SUM_W-1:0] sum_ff;
   logic [tfn_pkg::SUM_W-1:0] rem_ff;
   logic [tfn_pkg::QUO_W-1:0] num_ff, quo_ff;
   logic [tfn_pkg::ROOT_W-1:0] val_ff, res_ff, bit_ff;
   logic signed [tfn_pkg::NRM_W-1:0] nrm_ff [3];
   logic signed [tfn_pkg::NRM_W-1:0] out_ff [3];
   logic              out_zero_ff;

   assign ext_v   = EW'(req_vertex_index);
   assign ext_a   = EW'(req_corner_a);
   assign ext_b   = EW'(req_corner_b);
   assign ext_c   = EW'(req_corner_c);
   assign wr_en   = (cmd.op == tfn_pkg::OP_LOAD) && (ext_v < EW'(MAX_VERTICES));
   assign wr_addr = ext_v[AW-1:0];

   always_comb begin
      case (cmd.op)
         tfn_pkg::OP_RD_B: rd_addr = addr_ff[1];
         tfn_pkg::OP_RD_C: rd_addr = addr_ff[2];
         default:          rd_addr = addr_ff[0];
      endcase
   end

   tfn_ram #(.WIDTH(VEC_W), .DEPTH(MAX_VERTICES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_pos_x, req_pos_y, req_pos_z}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // multiplier operand select: cr0 = y*z' - z*y', cr1 = z*x' - x*z', cr2 = x*y' - y*x'
   edge_type mul_a, mul_b;
   logic signed [tfn_pkg::PROD_W-1:0] mul_p;
   always_comb begin
      case (cmd.step)
         5'd0:    begin mul_a = e0_ff[1]; mul_b = e1_ff[2]; end
         5'd1:    begin mul_a = e0_ff[2]; mul_b = e1_ff[1]; end
         5'd2:    begin mul_a = e0_ff[2]; mul_b = e1_ff[0]; end
         5'd3:    begin mul_a = e0_ff[0]; mul_b = e1_ff[2]; end
         5'd4:    begin mul_a = e0_ff[0]; mul_b = e1_ff[1]; end
         default: begin mul_a = e0_ff[1]; mul_b = e1_ff[0]; end
      endcase
      mul_p = mul_a * mul_b;
   end

   logic [tfn_pkg::STEP_W-1:0] acc_idx;
   logic [1:0]                 acc_sel;
   cross_type                  prod_ext;
   assign acc_idx  = cmd.step - 1'b1;
   assign acc_sel  = acc_idx[2:1];
   assign prod_ext = {prod_ff[tfn_pkg::PROD_W-1], prod_ff};

   // divider and square root step logic
   logic [tfn_pkg::SUM_W:0]    div_t;
   logic                       div_ge;
   logic [tfn_pkg::ROOT_W-1:0] sq_trial;
   logic                       sq_ge;
   assign div_t    = {rem_ff, num_ff[tfn_pkg::QUO_W-1]};
   assign div_ge   = div_t >= {1'b0, sum_ff};
   assign sq_trial = res_ff + bit_ff;
   assign sq_ge    = val_ff >= sq_trial;

   logic [tfn_pkg::U_W-1:0] sq_op;
   assign sq_op = mag_ff[cmd.step[1:0]][tfn_pkg::U_W-1:0];

   always_ff @(posedge clock) begin
      case (cmd.op)
         tfn_pkg::OP_ACCEPT: begin
            addr_ff[0] <= ext_a[AW-1:0];
            addr_ff[1] <= ext_b[AW-1:0];
            addr_ff[2] <= ext_c[AW-1:0];
            inr_ff[0]  <= ext_a < EW'(MAX_VERTICES);
            inr_ff[1]  <= ext_b < EW'(MAX_VERTICES);
            inr_ff[2]  <= ext_c < EW'(MAX_VERTICES);
         end
         tfn_pkg::OP_RD_B, tfn_pkg::OP_RD_C, tfn_pkg::OP_CAP_C: begin
            for (int k = 0; k < 3; k++) begin
               if (cmd.op == tfn_pkg::OP_RD_B) begin
                  vtx_ff[0][k] <= inr_ff[0] ? rd_data[(2-k)*tfn_pkg::POS_W +: tfn_pkg::POS_W]
                                            : '0;
               end else if (cmd.op == tfn_pkg::OP_RD_C) begin
                  vtx_ff[1][k] <= inr_ff[1] ? rd_data[(2-k)*tfn_pkg::POS_W +: tfn_pkg::POS_W]
                                            : '0;
               end else begin
                  vtx_ff[2][k] <= inr_ff[2] ? rd_data[(2-k)*tfn_pkg::POS_W +: tfn_pkg::POS_W]
                                            : '0;
               end
            end
         end
         tfn_pkg::OP_EDGE: begin
            for (int k = 0; k < 3; k++) begin
               e0_ff[k] <= {vtx_ff[1][k][tfn_pkg::POS_W-1], vtx_ff[1][k]}
                         - {vtx_ff[0][k][tfn_pkg::POS_W-1], vtx_ff[0][k]};
               e1_ff[k] <= {vtx_ff[2][k][tfn_pkg::POS_W-1], vtx_ff[2][k]}
                         - {vtx_ff[0][k][tfn_pkg::POS_W-1], vtx_ff[0][k]};
            end
         end
         tfn_pkg::OP_MUL: begin
            // product registered, folded into the cross term on the next multiply step
            prod_ff <= mul_p;
            if (cmd.step != '0) begin
               if (!acc_idx[0]) begin
                  cr_ff[acc_sel] <= prod_ext;
               end else begin
                  cr_ff[acc_sel] <= cr_ff[acc_sel] - prod_ext;
               end
            end
         end
         tfn_pkg::OP_ABS: begin
            for (int k = 0; k < 3; k++) begin
               cross_type neg_v;
               neg_v     = -cr_ff[k];
               neg_ff[k] <= cr_ff[k][tfn_pkg::CROSS_W-1];
               mag_ff[k] <= cr_ff[k][tfn_pkg::CROSS_W-1] ? neg_v[tfn_pkg::MAG_W-1:0]
                                                        : cr_ff[k][tfn_pkg::MAG_W-1:0];
            end
         end
         tfn_pkg::OP_MAX: begin
            logic [tfn_pkg::MAG_W-1:0] m01;
            m01 = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
            max_ff  <= (m01 > mag_ff[2]) ? m01 : mag_ff[2];
            zero_ff <= (mag_ff[0] == '0) && (mag_ff[1] == '0) && (mag_ff[2] == '0);
         end
         tfn_pkg::OP_NORM: begin
            if (max_ff < tfn_pkg::MAG_W'(1 << tfn_pkg::NORM_LO_EXP)) begin
               max_ff <= max_ff << 1;
               for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] << 1;
            end else begin
               max_ff <= max_ff >> 1;
               for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] >> 1;
            end
         end
         tfn_pkg::OP_SQ: begin
            sq_ff[cmd.step[1:0]] <= sq_op * sq_op;
         end
         tfn_pkg::OP_SUM: begin
            sum_ff <= tfn_pkg::SUM_W'(sq_ff[0]) + tfn_pkg::SUM_W'(sq_ff[1])
                    + tfn_pkg::SUM_W'(sq_ff[2]);
         end
         tfn_pkg::OP_DIV_INIT: begin
            // numerator is u^2 * 2^28; its top part starts in the remainder
            rem_ff <= tfn_pkg::SUM_W'(sq_ff[cmd.comp] >> 1);
            num_ff <= {sq_ff[cmd.comp][0], (tfn_pkg::QUO_W-1)'(0)};
            quo_ff <= '0;
         end
         tfn_pkg::OP_DIV_STEP: begin
            rem_ff <= div_ge ? tfn_pkg::SUM_W'(div_t - {1'b0, sum_ff})
                             : div_t[tfn_pkg::SUM_W-1:0];
            quo_ff <= {quo_ff[tfn_pkg::QUO_W-2:0], div_ge};
            num_ff <= num_ff << 1;
         end
         tfn_pkg::OP_SQRT_INIT: begin
            val_ff <= tfn_pkg::ROOT_W'(quo_ff);
            res_ff <= '0;
            bit_ff <= tfn_pkg::ROOT_W'(1) << (tfn_pkg::QUO_W - 1);
         end
         tfn_pkg::OP_SQRT_STEP: begin
            if (sq_ge) begin
               val_ff <= val_ff - sq_trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         tfn_pkg::OP_STORE: begin
            nrm_ff[cmd.comp] <= neg_ff[cmd.comp] ? -res_ff[tfn_pkg::NRM_W-1:0]
                                                 : res_ff[tfn_pkg::NRM_W-1:0];
         end
         tfn_pkg::OP_RSP: begin
            for (int k = 0; k < 3; k++) out_ff[k] <= zero_ff ? '0 : nrm_ff[k];
            out_zero_ff <= zero_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.zero    = zero_ff;
   assign status.norm_ok = (max_ff >= tfn_pkg::MAG_W'(1 << tfn_pkg::NORM_LO_EXP))
                        && (max_ff <  tfn_pkg::MAG_W'(1 << tfn_pkg::NORM_HI_EXP));

   assign rsp_normal_x  = out_ff[0];
   assign rsp_normal_y  = out_ff[1];
   assign rsp_normal_z  = out_ff[2];
   assign rsp_zero_area = out_zero_ff;
endmodule

// ----- rtl/core/tfn_checker.sv -----
// tfn_checker: port-level assertions for triangle_face_normal, bound to the top.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
module tfn_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             req_type,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [tfn_pkg::NRM_W-1:0] rsp_normal_x,
   input logic signed [tfn_pkg::NRM_W-1:0] rsp_normal_y,
   input logic signed [tfn_pkg::NRM_W-1:0] rsp_normal_z,
   input logic                             rsp_zero_area
);
   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_normal_x)
         && $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_zero_area))
      else $error("result changed under stall");

   // degenerate face gives a zero normal
   a_zero_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_area |-> rsp_normal_x == 0 && rsp_normal_y == 0
         && rsp_normal_z == 0)
      else $error("zero_area with nonzero normal");

   // a real normal is never all zero
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_area |-> rsp_normal_x != 0 || rsp_normal_y != 0
         || rsp_normal_z != 0)
      else $error("normal lost its length");

   // an accepted triangle item makes the input stall
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type |=> req_stall)
      else $error("input open while triangle in flight");
endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_type      (req_type),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_normal_x  (rsp_normal_x),
   .rsp_normal_y  (rsp_normal_y),
   .rsp_normal_z  (rsp_normal_z),
   .rsp_zero_area (rsp_zero_area)
);
